### rtl/core/rsdes_pkg.sv
// Package for the RTCP source-description phone extractor.
// Holds the parse phases, result codes, register indexes and the result record.
// Used by rsdes_parser, rsdes_fifo and rtcp_sdes_phone_extractor_core.
`default_nettype none

package rsdes_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned OFFSET_W   = 18;

   localparam logic [7:0] SDES_TYPE_RESET   = 8'd202;
   localparam logic [7:0] WANTED_TYPE_RESET = 8'd4;
   localparam logic [7:0] END_TYPE_RESET    = 8'd0;
   localparam logic [1:0] RTP_VERSION       = 2'd2;

   typedef enum logic [1:0] {
      CSR_SDES_TYPE   = 2'd0,
      CSR_WANTED_TYPE = 2'd1,
      CSR_END_TYPE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_BAD_VERSION  = 2'd0,
      ERR_PAST_PAYLOAD = 2'd1,
      ERR_SHORT_HEADER = 2'd2
   } error_code_type;

   typedef enum logic [3:0] {
      PH_HDR0 = 4'd0,
      PH_HDR1 = 4'd1,
      PH_HDR2 = 4'd2,
      PH_HDR3 = 4'd3,
      PH_SSRC = 4'd4,
      PH_TYPE = 4'd5,
      PH_LEN  = 4'd6,
      PH_DATA = 4'd7,
      PH_SKIP = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       number_last;
      logic [1:0] error_code;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/rsdes_fifo.sv
// Small result queue that takes up to two results per cycle and gives one.
// Depends on rsdes_pkg for the result record.
`default_nettype none

module rsdes_fifo #(
   parameter int unsigned Depth = rsdes_pkg::FIFO_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push0,
   input  wire                   push1,
   input  rsdes_pkg::result_type data0,
   input  rsdes_pkg::result_type data1,
   output logic                  space2,
   input  wire                   pop,
   output logic                  out_valid,
   output rsdes_pkg::result_type out_data
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   rsdes_pkg::result_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign space2    = (count_ff <= CntW'(Depth - 2));
   assign do_pop    = pop && out_valid;
   assign wr_next   = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push0 && push1) begin
         wr_ptr_in = ptr_inc(wr_next);
      end else if (push0) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push0) + CntW'(push1) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= data0;
      end
      if (push0 && push1) begin
         mem_ff[wr_next] <= data1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue count exceeds its depth");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("second result pushed without a first");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      ##1 count_ff == $past(count_ff) + CntW'($past(push0)) + CntW'($past(push1))
                      - CntW'($past(do_pop)))
      else $error("result queue count lost track of pushes and pops");

endmodule

`default_nettype wire

### rtl/core/rsdes_parser.sv
// Input register, configuration registers and the byte-level parse state.
// Produces up to two results per accepted item. Depends on rsdes_pkg.
`default_nettype none

module rsdes_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  wire  [7:0]            in_byte,
   input  wire                   in_end,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_index,
   input  wire  [7:0]            csr_wdata,
   input  wire                   space2,
   output logic                  push0,
   output logic                  push1,
   output rsdes_pkg::result_type res0,
   output rsdes_pkg::result_type res1
);

   localparam int unsigned OffW = rsdes_pkg::OFFSET_W;

   logic                 valid_ff;
   logic [7:0]           byte_ff;
   logic                 end_ff;
   logic [7:0]           sdes_type_ff, wanted_type_ff, end_type_ff;

   rsdes_pkg::phase_type phase_ff, phase_in;
   logic [OffW-1:0]      offset_ff, offset_in;
   logic [OffW-1:0]      pkt_ff, pkt_in;
   logic                 is_sdes_ff, is_sdes_in;
   logic [7:0]           left_ff, left_in;
   logic                 wanted_ff, wanted_in;
   logic                 drop_ff, drop_in;
   logic                 vbad_ff, vbad_in;

   logic                 step;
   logic                 at_last;
   logic [OffW-1:0]      hdr_len;
   logic                 clear_sub;
   logic                 emit_valid;
   rsdes_pkg::result_type emit_res;
   logic                 fail_valid;
   rsdes_pkg::result_type fail_res;

   assign step     = valid_ff && space2;
   assign in_ready = !valid_ff || space2;
   assign at_last  = (offset_ff >= pkt_ff);
   assign hdr_len  = {pkt_ff[7:0], byte_ff, 2'b11};

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      pkt_in     = pkt_ff;
      is_sdes_in = is_sdes_ff;
      left_in    = left_ff;
      wanted_in  = wanted_ff;
      drop_in    = drop_ff;
      vbad_in    = vbad_ff;
      clear_sub  = 1'b0;
      emit_valid = 1'b0;
      emit_res   = '0;
      fail_valid = 1'b0;
      fail_res   = '0;
      fail_res.kind = rsdes_pkg::KIND_ERROR;

      if (step) begin
         if (drop_ff) begin
            if (end_ff) begin
               clear_sub = 1'b1;
               drop_in   = 1'b0;
            end
         end else begin
            unique case (phase_ff)
               rsdes_pkg::PH_HDR0: begin
                  vbad_in = (byte_ff[7:6] != rsdes_pkg::RTP_VERSION);
                  if (end_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_SHORT_HEADER;
                  end else begin
                     phase_in = rsdes_pkg::PH_HDR1;
                  end
               end
               rsdes_pkg::PH_HDR1: begin
                  is_sdes_in = (byte_ff == sdes_type_ff);
                  if (end_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_SHORT_HEADER;
                  end else begin
                     phase_in = rsdes_pkg::PH_HDR2;
                  end
               end
               rsdes_pkg::PH_HDR2: begin
                  pkt_in = OffW'(byte_ff);
                  if (end_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_SHORT_HEADER;
                  end else begin
                     phase_in = rsdes_pkg::PH_HDR3;
                  end
               end
               rsdes_pkg::PH_HDR3: begin
                  if (vbad_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_BAD_VERSION;
                  end else if (hdr_len == OffW'(3)) begin
                     clear_sub = 1'b1;
                  end else if (end_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_PAST_PAYLOAD;
                  end else begin
                     pkt_in    = hdr_len;
                     phase_in  = is_sdes_ff ? rsdes_pkg::PH_SSRC : rsdes_pkg::PH_SKIP;
                     offset_in = OffW'(4);
                  end
               end
               default: begin
                  unique case (phase_ff)
                     rsdes_pkg::PH_SSRC: begin
                        if (offset_ff >= OffW'(7)) begin
                           phase_in = rsdes_pkg::PH_TYPE;
                        end
                     end
                     rsdes_pkg::PH_TYPE: begin
                        if (byte_ff == end_type_ff) begin
                           phase_in = rsdes_pkg::PH_SKIP;
                        end else begin
                           wanted_in = (byte_ff == wanted_type_ff);
                           phase_in  = rsdes_pkg::PH_LEN;
                        end
                     end
                     rsdes_pkg::PH_LEN: begin
                        left_in = byte_ff;
                        if (byte_ff == 8'd0 || at_last || end_ff) begin
                           emit_valid    = wanted_ff;
                           emit_res.kind = rsdes_pkg::KIND_EMPTY;
                           phase_in      = rsdes_pkg::PH_TYPE;
                        end else begin
                           phase_in = rsdes_pkg::PH_DATA;
                        end
                     end
                     rsdes_pkg::PH_DATA: begin
                        emit_valid           = wanted_ff;
                        emit_res.kind        = rsdes_pkg::KIND_BYTE;
                        emit_res.out_byte    = byte_ff;
                        emit_res.number_last = (left_ff <= 8'd1) || at_last || end_ff;
                        left_in              = left_ff - 8'd1;
                        if (left_ff == 8'd1) begin
                           phase_in = rsdes_pkg::PH_TYPE;
                        end
                     end
                     default: begin
                        phase_in = rsdes_pkg::PH_SKIP;
                     end
                  endcase

                  if (at_last) begin
                     clear_sub = 1'b1;
                  end else if (end_ff) begin
                     fail_valid          = 1'b1;
                     fail_res.error_code = rsdes_pkg::ERR_PAST_PAYLOAD;
                  end else begin
                     offset_in = offset_ff + 1'b1;
                  end
               end
            endcase

            if (fail_valid) begin
               clear_sub = 1'b1;
               drop_in   = !end_ff;
            end
         end

         if (clear_sub) begin
            phase_in   = rsdes_pkg::PH_HDR0;
            offset_in  = '0;
            pkt_in     = '0;
            is_sdes_in = 1'b0;
            left_in    = '0;
            wanted_in  = 1'b0;
            vbad_in    = 1'b0;
         end
      end
   end

   assign push0 = emit_valid || fail_valid;
   assign push1 = emit_valid && fail_valid;
   assign res0  = emit_valid ? emit_res : fail_res;
   assign res1  = fail_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         end_ff  <= in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sdes_type_ff   <= rsdes_pkg::SDES_TYPE_RESET;
         wanted_type_ff <= rsdes_pkg::WANTED_TYPE_RESET;
         end_type_ff    <= rsdes_pkg::END_TYPE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rsdes_pkg::CSR_SDES_TYPE:   sdes_type_ff   <= csr_wdata;
            rsdes_pkg::CSR_WANTED_TYPE: wanted_type_ff <= csr_wdata;
            rsdes_pkg::CSR_END_TYPE:    end_type_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rsdes_pkg::PH_HDR0;
         offset_ff  <= '0;
         pkt_ff     <= '0;
         is_sdes_ff <= 1'b0;
         left_ff    <= '0;
         wanted_ff  <= 1'b0;
         drop_ff    <= 1'b0;
         vbad_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         pkt_ff     <= pkt_in;
         is_sdes_ff <= is_sdes_in;
         left_ff    <= left_in;
         wanted_ff  <= wanted_in;
         drop_ff    <= drop_in;
         vbad_ff    <= vbad_in;
      end
   end

   a_drop_at_header: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (phase_ff == rsdes_pkg::PH_HDR0))
      else $error("dropping while a sub-packet is still open");

   a_offset_in_packet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rsdes_pkg::PH_HDR0 && phase_ff != rsdes_pkg::PH_HDR1 &&
       phase_ff != rsdes_pkg::PH_HDR2 && phase_ff != rsdes_pkg::PH_HDR3)
      |-> (offset_ff <= pkt_ff && offset_ff >= OffW'(4)))
      else $error("offset left the current sub-packet");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !step |-> !push0 && !push1)
      else $error("result produced without an item in work");

endmodule

`default_nettype wire

### rtl/core/rtcp_sdes_phone_extractor_core.sv
// Top level of the RTCP source-description phone extractor.
// Instantiates rsdes_parser and rsdes_fifo; depends on rsdes_pkg.
//
// The block takes one payload byte per cycle on the req_ stream while the result
// queue has room, with tlast on the final byte of each compound payload, and
// returns phone number bytes, empty-number marks and error reports on the rsp_
// stream. A byte is held in the input register until the queue has room for two
// results, then parsed, and its results are written into a small result queue.
// One byte gives at most two results; the parser stalls its input only when the
// queue has fewer than two free entries, so with the default queue of four the
// block sustains one byte per cycle whenever the result side takes one result
// per cycle. The csr_ port writes the three type-code registers and should only
// be used while the block is idle.
`default_nettype none

module rtcp_sdes_phone_extractor_core #(
   parameter int unsigned FifoDepth = rsdes_pkg::FIFO_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] in_byte
   input  wire         req_tlast,   // payload_end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [9:8] error_code, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // number_last
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_wdata
);

   logic                  space2;
   logic                  push0, push1;
   rsdes_pkg::result_type res0, res1;
   rsdes_pkg::result_type out_res;

   rsdes_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .space2    (space2),
      .push0     (push0),
      .push1     (push1),
      .res0      (res0),
      .res1      (res1)
   );

   rsdes_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .data0     (res0),
      .data1     (res1),
      .space2    (space2),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_res)
   );

   assign rsp_tdata = {6'd0, out_res.error_code, out_res.out_byte};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.number_last;

endmodule

`default_nettype wire

### tb/sdes_phone_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the RTCP source-description phone extractor: follows the csr_, req_ and
// rsp_ channels, predicts every result from the accepted payload bytes and compares them.
// Depends on rsdes_pkg for the result record, the phase, kind, code and register names.

module sdes_phone_scoreboard
   import rsdes_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [7:0]  req_tdata,
   input  wire         req_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [15:0] rsp_tdata,
   input  wire  [1:0]  rsp_tuser,
   input  wire         rsp_tlast,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_wdata,
   output int          failures,
   output int          pending
);

   localparam logic [1:0] CODE_NONE = 2'd0;

   logic [7:0]          sdes_code;
   logic [7:0]          wanted_code;
   logic [7:0]          end_code;

   phase_type           walk_phase;
   logic [OFFSET_W-1:0] byte_index;
   logic [OFFSET_W-1:0] last_index;
   logic                in_sdes;
   logic [7:0]          item_left;
   logic                item_wanted;
   logic                drop_rest;
   logic                bad_version;

   result_type          predicted_results[$];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      failures++;
   endtask

   task automatic restart_subpacket();
      walk_phase  = PH_HDR0;
      byte_index  = '0;
      last_index  = '0;
      in_sdes     = 1'b0;
      item_left   = '0;
      item_wanted = 1'b0;
      bad_version = 1'b0;
   endtask

   task automatic push_result(input kind_type k, input logic [7:0] b, input logic last,
                              input logic [1:0] code);
      result_type r;
      r.kind        = k;
      r.out_byte    = b;
      r.number_last = last;
      r.error_code  = code;
      predicted_results.push_back(r);
   endtask

   // An error on a payload's final byte leaves nothing to drop.
   task automatic raise_error(input error_code_type code, input logic at_end);
      push_result(KIND_ERROR, 8'd0, 1'b0, code);
      restart_subpacket();
      drop_rest = !at_end;
   endtask

   task automatic parse_payload_byte(input logic [7:0] b, input logic at_end);
      logic [OFFSET_W-1:0] cur;
      logic                at_last;
      if (drop_rest) begin
         if (at_end) begin
            restart_subpacket();
            drop_rest = 1'b0;
         end
         return;
      end
      case (walk_phase)
         PH_HDR0: begin
            bad_version = (b[7:6] != RTP_VERSION);
            if (at_end) raise_error(ERR_SHORT_HEADER, 1'b1);
            else walk_phase = PH_HDR1;
            return;
         end
         PH_HDR1: begin
            in_sdes = (b == sdes_code);
            if (at_end) raise_error(ERR_SHORT_HEADER, 1'b1);
            else walk_phase = PH_HDR2;
            return;
         end
         PH_HDR2: begin
            last_index = {{(OFFSET_W-8){1'b0}}, b};
            if (at_end) raise_error(ERR_SHORT_HEADER, 1'b1);
            else walk_phase = PH_HDR3;
            return;
         end
         PH_HDR3: begin
            if (bad_version) begin
               raise_error(ERR_BAD_VERSION, at_end);
            end else begin
               last_index = {last_index[7:0], b, 2'b11};
               if (last_index == OFFSET_W'(3)) begin
                  restart_subpacket();
               end else if (at_end) begin
                  raise_error(ERR_PAST_PAYLOAD, 1'b1);
               end else begin
                  walk_phase = in_sdes ? PH_SSRC : PH_SKIP;
                  byte_index = OFFSET_W'(4);
               end
            end
            return;
         end
         default: ;
      endcase

      cur     = byte_index;
      at_last = (cur >= last_index);
      case (walk_phase)
         PH_SSRC: begin
            if (cur >= OFFSET_W'(7)) walk_phase = PH_TYPE;
         end
         PH_TYPE: begin
            if (b == end_code) begin
               walk_phase = PH_SKIP;
            end else begin
               item_wanted = (b == wanted_code);
               walk_phase  = PH_LEN;
            end
         end
         PH_LEN: begin
            item_left = b;
            if (b == 8'd0 || at_last || at_end) begin
               if (item_wanted) push_result(KIND_EMPTY, 8'd0, 1'b0, CODE_NONE);
               walk_phase = PH_TYPE;
            end else begin
               walk_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (item_wanted)
               push_result(KIND_BYTE, b, (item_left <= 8'd1) || at_last || at_end, CODE_NONE);
            item_left = item_left - 8'd1;
            if (item_left == 8'd0) walk_phase = PH_TYPE;
         end
         default: walk_phase = PH_SKIP;
      endcase

      if (at_last) restart_subpacket();
      else if (at_end) raise_error(ERR_PAST_PAYLOAD, 1'b1);
      else byte_index = cur + OFFSET_W'(1);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         sdes_code   = SDES_TYPE_RESET;
         wanted_code = WANTED_TYPE_RESET;
         end_code    = END_TYPE_RESET;
         restart_subpacket();
         drop_rest   = 1'b0;
         predicted_results.delete();
         failures    = 0;
         pending    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected, kind %0d byte %02h",
                                         rsp_tuser, rsp_tdata[7:0]));
            end else begin
               want = predicted_results.pop_front();
               if (rsp_tuser != want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
               if (rsp_tdata[7:0] != want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_tdata[7:0], want.out_byte));
               if (rsp_tlast != want.number_last)
                  report_mismatch($sformatf("number_last %0b, expected %0b",
                                            rsp_tlast, want.number_last));
               if (rsp_tdata[9:8] != want.error_code)
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            rsp_tdata[9:8], want.error_code));
               if (rsp_tdata[15:10] != '0)
                  report_mismatch($sformatf("tdata padding %02h is not zero", rsp_tdata[15:10]));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SDES_TYPE:   sdes_code   = csr_wdata;
               CSR_WANTED_TYPE: wanted_code = csr_wdata;
               CSR_END_TYPE:    end_code    = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_payload_byte(req_tdata, req_tlast);
         pending <= predicted_results.size();
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the phone extractor testbench: clock, reset, register writes and payload stimulus.
// Instantiates rtcp_sdes_phone_extractor_core and sdes_phone_scoreboard; uses rsdes_pkg.

module testbench;
   import rsdes_pkg::*;

   localparam logic [1:0] CSR_SPARE    = 2'd3;
   localparam int         RANDOM_ITEMS = 2000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = 2'd0;
   logic [7:0]  csr_wdata  = 8'd0;

   int          failures;
   int          pending;

   bit          req_eager;
   bit          rsp_eager;
   int          bytes_sent;
   logic [7:0]  frame[$];
   logic [7:0]  cfg_sdes   = SDES_TYPE_RESET;
   logic [7:0]  cfg_wanted = WANTED_TYPE_RESET;
   logic [7:0]  cfg_end    = END_TYPE_RESET;

   rtcp_sdes_phone_extractor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sdes_phone_scoreboard results_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int gap;
      forever begin
         gap = rsp_eager ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] sdes, input logic [7:0] wanted,
                                input logic [7:0] stop);
      wait_idle();
      write_register(CSR_SDES_TYPE, sdes);
      write_register(CSR_WANTED_TYPE, wanted);
      write_register(CSR_END_TYPE, stop);
      write_register(CSR_SPARE, 8'($urandom));
      cfg_sdes   = sdes;
      cfg_wanted = wanted;
      cfg_end    = stop;
   endtask

   function automatic logic [7:0] pick_code(input logic [7:0] fallback);
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'($urandom);
         default: return fallback;
      endcase
   endfunction

   task automatic add_sdes(input int words);
      logic [7:0] items[$];
      logic [7:0] t;
      int         room;
      int         len;
      int         pick;
      room = words * 4 - 4;
      frame.push_back({2'b10, 6'($urandom)});
      frame.push_back(cfg_sdes);
      frame.push_back(8'(words >> 8));
      frame.push_back(8'(words));
      repeat (4) frame.push_back(8'($urandom));
      while (items.size() < room) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            items.push_back(cfg_end);
            while (items.size() < room) items.push_back(8'($urandom));
         end else begin
            if (pick < 7) begin
               t = cfg_wanted;
            end else begin
               do t = 8'($urandom); while (t == cfg_wanted || t == cfg_end);
            end
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            items.push_back(t);
            items.push_back(8'(len));
            repeat (len) items.push_back(8'($urandom));
         end
      end
      for (int i = 0; i < room; i++) frame.push_back(items[i]);
   endtask

   task automatic add_other(input int words);
      logic [7:0] t;
      do t = 8'($urandom); while (t == cfg_sdes);
      frame.push_back({2'b10, 6'($urandom)});
      frame.push_back(t);
      frame.push_back(8'd0);
      frame.push_back(8'(words));
      repeat (words * 4) frame.push_back(8'($urandom));
   endtask

   // Most payloads are well formed; a few are cut short, carry a bad version or a length
   // word far beyond the payload, and some are plain noise.
   task automatic send_random_payload();
      int         mode;
      int         keep;
      logic [1:0] ver;
      frame.delete();
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) < 7) add_sdes($urandom_range(1, 6));
            else add_other($urandom_range(0, 3));
         end
         case (mode)
            1, 2: begin
               keep = $urandom_range(1, frame.size() - 1);
               while (frame.size() > keep) void'(frame.pop_back());
            end
            3: begin
               ver = 2'($urandom_range(0, 2));
               if (ver == 2'd2) ver = 2'd3;
               frame[0] = {ver, frame[0][5:0]};
            end
            4: frame[2] = 8'($urandom_range(1, 255));
            default: ;
         endcase
      end
      req_eager = ($urandom_range(0, 4) == 0);
      rsp_eager = ($urandom_range(0, 4) == 0);
      send_frame();
   endtask

   initial begin
      int payloads;
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero-length and one-byte phone items, then the end item and padding.
      frame = '{8'h80, 8'hCA, 8'h00, 8'h03, 8'h11, 8'h22, 8'h33, 8'h44,
                8'h04, 8'h00, 8'h04, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00};
      send_frame();
      // Short header.
      frame = '{8'h80};
      send_frame();
      // Bad version, with the rest of the payload dropped.
      frame = '{8'h40, 8'hCA, 8'h00, 8'h01, 8'hFF};
      send_frame();
      // Largest length word on a payload that ends with the header.
      frame = '{8'hBF, 8'hCA, 8'hFF, 8'hFF};
      send_frame();

      load_settings(8'hFF, 8'h00, 8'hFF);
      repeat (3) send_random_payload();
      load_settings(8'h00, 8'hFF, 8'h00);
      repeat (3) send_random_payload();
      load_settings(SDES_TYPE_RESET, WANTED_TYPE_RESET, END_TYPE_RESET);

      bytes_sent = 0;
      payloads   = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         if (payloads % 12 == 11)
            load_settings(pick_code(SDES_TYPE_RESET), pick_code(WANTED_TYPE_RESET),
                          pick_code(END_TYPE_RESET));
         send_random_payload();
         payloads++;
      end

      req_tvalid <= 1'b0;
      for (waited = 0; pending != 0 && waited < 20000; waited++) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
